// ===== src/ihf_pkg.sv =====
package ihf_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } ihf_in_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [7:0]  protocol;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [5:0]  header_bytes;
    logic [15:0] payload_length;
  } ihf_out_t;

  localparam logic [3:0] VERDICT_ICMP     = 4'd0;
  localparam logic [3:0] VERDICT_UDP      = 4'd1;
  localparam logic [3:0] VERDICT_TCP      = 4'd2;
  localparam logic [3:0] VERDICT_UNKNOWN  = 4'd3;
  localparam logic [3:0] VERDICT_SHORT    = 4'd4;
  localparam logic [3:0] VERDICT_VERSION  = 4'd5;
  localparam logic [3:0] VERDICT_LENGTH   = 4'd6;
  localparam logic [3:0] VERDICT_CHECKSUM = 4'd7;
  localparam logic [3:0] VERDICT_NOT_OURS = 4'd8;

  localparam logic [15:0] MIN_HEADER     = 16'd20;
  localparam logic [15:0] COUNT_MAX      = 16'hffff;
  localparam logic [15:0] SUM_GOOD       = 16'hffff;
  localparam logic [3:0]  VERSION_IPV4   = 4'd4;
  localparam logic [31:0] ADDR_BROADCAST = 32'hffffffff;
  localparam logic [31:0] ADDR_LOOPBACK  = 32'h7f000001;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;

  localparam logic [15:0] POS_VERSION    = 16'd0;
  localparam logic [15:0] POS_LENGTH_HI  = 16'd2;
  localparam logic [15:0] POS_LENGTH_LO  = 16'd3;
  localparam logic [15:0] POS_PROTOCOL   = 16'd9;
  localparam logic [15:0] POS_SOURCE     = 16'd12;
  localparam logic [15:0] POS_DEST       = 16'd16;
  localparam logic [15:0] POS_DEST_END   = 16'd19;

endpackage

// ===== src/ihf_in_stage.sv =====
module ihf_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ihf_pkg::ihf_in_t in_word,
  input  logic             take,
  output logic             held_valid,
  output ihf_pkg::ihf_in_t held_word
);
  import ihf_pkg::*;

  assign in_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_word <= in_word;
    end
  end

endmodule

// ===== src/ihf_parser.sv =====
module ihf_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       local_address,
  input  logic              byte_valid,
  input  ihf_pkg::ihf_in_t  byte_word,
  input  logic              out_free,
  output logic              take,
  output logic              result_load,
  output ihf_pkg::ihf_out_t result_word
);
  import ihf_pkg::*;

  logic [15:0] byte_count;
  logic [5:0]  header_length;
  logic [3:0]  version_field;
  logic [15:0] total_length;
  logic [15:0] sum_accumulator;
  logic [7:0]  pending_high_byte;
  logic [7:0]  captured_protocol;
  logic [31:0] captured_source;
  logic [31:0] captured_destination;

  logic [15:0] byte_count_next;
  logic [5:0]  header_length_next;
  logic [3:0]  version_field_next;
  logic [15:0] total_length_next;
  logic [15:0] sum_accumulator_next;
  logic [7:0]  pending_high_byte_next;
  logic [7:0]  captured_protocol_next;
  logic [31:0] captured_source_next;
  logic [31:0] captured_destination_next;

  logic [7:0]  b;
  logic [16:0] sum_raw;
  logic [15:0] hl_wide;
  logic        dest_ok;
  logic [3:0]  verdict;

  assign b = byte_word.data_byte;
  assign take = byte_valid && (!byte_word.last_byte || out_free);
  assign result_load = take && byte_word.last_byte;

  always_comb begin
    version_field_next        = version_field;
    header_length_next        = header_length;
    total_length_next         = total_length;
    captured_protocol_next    = captured_protocol;
    captured_source_next      = captured_source;
    captured_destination_next = captured_destination;
    pending_high_byte_next    = pending_high_byte;
    sum_accumulator_next      = sum_accumulator;
    sum_raw = {1'b0, sum_accumulator} + {1'b0, pending_high_byte, b};

    if (byte_count == POS_VERSION) begin
      version_field_next = b[7:4];
      header_length_next = {b[3:0], 2'b00};
    end else if (byte_count == POS_LENGTH_HI) begin
      total_length_next = {b, total_length[7:0]};
    end else if (byte_count == POS_LENGTH_LO) begin
      total_length_next = {total_length[15:8], b};
    end else if (byte_count == POS_PROTOCOL) begin
      captured_protocol_next = b;
    end else if (byte_count >= POS_SOURCE && byte_count < POS_DEST) begin
      captured_source_next = {captured_source[23:0], b};
    end else if (byte_count >= POS_DEST && byte_count <= POS_DEST_END) begin
      captured_destination_next = {captured_destination[23:0], b};
    end

    // header words only, end-around carry
    if (byte_count < {10'd0, header_length_next}) begin
      if (!byte_count[0]) begin
        pending_high_byte_next = b;
      end else begin
        sum_accumulator_next = sum_raw[15:0] + {15'd0, sum_raw[16]};
      end
    end

    byte_count_next = (byte_count != COUNT_MAX) ? byte_count + 16'd1 : byte_count;
  end

  assign hl_wide = {10'd0, header_length_next};
  assign dest_ok = (captured_destination_next == local_address) ||
                   (captured_destination_next == ADDR_BROADCAST) ||
                   (captured_destination_next == ADDR_LOOPBACK);

  always_comb begin
    if (byte_count_next < MIN_HEADER) begin
      verdict = VERDICT_SHORT;
    end else if (version_field_next != VERSION_IPV4) begin
      verdict = VERDICT_VERSION;
    end else if (hl_wide < MIN_HEADER || hl_wide > byte_count_next ||
                 total_length_next > byte_count_next || total_length_next < hl_wide) begin
      verdict = VERDICT_LENGTH;
    end else if (sum_accumulator_next != SUM_GOOD) begin
      verdict = VERDICT_CHECKSUM;
    end else if (!dest_ok) begin
      verdict = VERDICT_NOT_OURS;
    end else begin
      case (captured_protocol_next)
        PROTO_ICMP: verdict = VERDICT_ICMP;
        PROTO_UDP:  verdict = VERDICT_UDP;
        PROTO_TCP:  verdict = VERDICT_TCP;
        default:    verdict = VERDICT_UNKNOWN;
      endcase
    end
  end

  always_comb begin
    result_word.verdict             = verdict;
    result_word.protocol            = captured_protocol_next;
    result_word.source_address      = captured_source_next;
    result_word.destination_address = captured_destination_next;
    result_word.header_bytes        = header_length_next;
    result_word.payload_length      = (verdict <= VERDICT_UNKNOWN) ?
                                      total_length_next - hl_wide : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || result_load) begin
      byte_count           <= '0;
      header_length        <= '0;
      version_field        <= '0;
      total_length         <= '0;
      sum_accumulator      <= '0;
      pending_high_byte    <= '0;
      captured_protocol    <= '0;
      captured_source      <= '0;
      captured_destination <= '0;
    end else if (take) begin
      byte_count           <= byte_count_next;
      header_length        <= header_length_next;
      version_field        <= version_field_next;
      total_length         <= total_length_next;
      sum_accumulator      <= sum_accumulator_next;
      pending_high_byte    <= pending_high_byte_next;
      captured_protocol    <= captured_protocol_next;
      captured_source      <= captured_source_next;
      captured_destination <= captured_destination_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    result_load |=> (byte_count == 16'd0 && sum_accumulator == 16'd0))
    else $error("packet state not cleared after last word");

  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    (take && !byte_word.last_byte && byte_count == COUNT_MAX) |=> (byte_count == COUNT_MAX))
    else $error("byte count wrapped");

  a_header_aligned: assert property (@(posedge clk) disable iff (rst)
    header_length[1:0] == 2'b00)
    else $error("header length not a multiple of four");

  a_reject_no_payload: assert property (@(posedge clk) disable iff (rst)
    (result_load && verdict > VERDICT_UNKNOWN) |-> (result_word.payload_length == 16'd0))
    else $error("payload length on a reject verdict");

endmodule

// ===== src/ihf_out_stage.sv =====
module ihf_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ihf_pkg::ihf_out_t load_word,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output ihf_pkg::ihf_out_t out_word
);
  import ihf_pkg::*;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= load_word;
    end
  end

endmodule

// ===== src/ipv4_receive_header_filter.sv =====
// ipv4 receive header filter
// in_word carries one packet byte per word, header first, last_byte set on
// the final byte. a word is taken at a clock edge with in_valid high and
// in_stall low. one verdict word leaves on out_word per packet, under the
// same valid/stall rule, once the last byte has passed the input register.
// bytes flow at one per cycle while in_stall is low: an input register holds
// the byte, the parser updates its packet state and forms the verdict in the
// same cycle, and the result register holds the verdict. non-last bytes
// keep flowing while a verdict waits in the result register; a last byte
// waits in the input register until the result register is free, and
// in_stall rises when the input register is full and cannot move on.
// cfg_wr_en/cfg_wr_data set the local address; write it only while idle.
// rst clears the local address, the packet state and both valid flags.
module ipv4_receive_header_filter (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ihf_pkg::ihf_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output ihf_pkg::ihf_out_t out_word,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data
);
  import ihf_pkg::*;

  logic [31:0] local_address;
  logic        take;
  logic        held_valid;
  ihf_in_t     held_word;
  logic        out_free;
  logic        result_load;
  ihf_out_t    result_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= '0;
    end else if (cfg_wr_en) begin
      local_address <= cfg_wr_data;
    end
  end

  ihf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .take       (take),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  ihf_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .local_address (local_address),
    .byte_valid    (held_valid),
    .byte_word     (held_word),
    .out_free      (out_free),
    .take          (take),
    .result_load   (result_load),
    .result_word   (result_word)
  );

  ihf_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (result_load),
    .load_word (result_word),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
